>>> rtl/tmtfc_pkg.sv
// shared constants, types and helpers of the move-to-front cache
package tmtfc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int COUNT_WIDTH = 8;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int TOT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENT_W = KEY_WIDTH + COUNT_WIDTH;
	localparam int THR_W = 8;
	localparam int LIM_W = 5;
	localparam int CFG_W = 8;

	// item commands
	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_LIMIT     = 1'b1;

	localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(2);
	localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(16);

	typedef logic [KEY_WIDTH-1:0]   key_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TOT_W-1:0]       tot_t;
	typedef logic [IDX_W-1:0]       idx_t;

	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		tot_t             limit;
	} cfg_t;

	typedef struct packed {
		logic   hit;
		count_t count;
		logic   promoted;
		logic   evicted;
		key_t   ev_key;
		count_t ev_hits;
		tot_t   occupancy;
	} result_t;

	// limit register brought into 1 .. MAX_ENTRIES
	function automatic tot_t clamp_limit(input logic [LIM_W-1:0] lim);
		tot_t res;
		if (lim == '0) begin
			res = tot_t'(1);
		end else if (int'(lim) > MAX_ENTRIES) begin
			res = tot_t'(MAX_ENTRIES);
		end else begin
			res = tot_t'(lim);
		end
		return res;
	endfunction

endpackage

>>> rtl/tmtfc_if.sv
// item channels: request in, result out
interface tmtfc_in_if;
	import tmtfc_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	key_t access_key;

	modport source(output valid, cmd, access_key, input ready);
	modport sink(input valid, cmd, access_key, output ready);
endinterface

interface tmtfc_out_if;
	import tmtfc_pkg::*;

	logic   valid;
	logic   ready;
	logic   hit;
	count_t entry_count;
	logic   promoted;
	logic   evicted;
	key_t   evicted_key;
	count_t evicted_hits;
	tot_t   occupancy;

	modport source(output valid, hit, entry_count, promoted, evicted, evicted_key,
		evicted_hits, occupancy, input ready);
	modport sink(input valid, hit, entry_count, promoted, evicted, evicted_key,
		evicted_hits, occupancy, output ready);
endinterface

>>> rtl/threshold_move_to_front_cache.sv
// Move-to-front key cache with hit-count promotion threshold.
//
// Channels: in_ch takes one item per access (cmd, access_key); out_ch
// returns exactly one result item for each, in order. An item is taken on a
// clock edge with valid and ready both high. Configuration goes through a
// plain write port (cfg_wen, cfg_idx, cfg_wdata): index 0 is the promotion
// threshold, index 1 the list length limit; write only while the block idles.
//
// Operation: all entries live in one ram with a registered read port. A clear
// goes straight to the done state, and its result is loaded into the output
// register once that register is free; the sequencer then returns to idle. An
// access runs a pipelined search over the list, then a pipelined shift that
// moves entries one place back when the entry goes to the front, then the
// front write, a limit check, the hand-off and the return to idle, with a
// tail read added when an entry is evicted. One item is worked on at a time.
//
// Reset empties the list and loads threshold 2 and limit 16. A finished
// result sits in an output register; the next item is taken while it waits,
// and the sequencer holds its next result until the receiver takes the first.
module threshold_move_to_front_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	tmtfc_in_if.sink                    in_ch,
	tmtfc_out_if.source                 out_ch,
	input  logic                        cfg_wen,
	input  logic                        cfg_idx,
	input  logic [tmtfc_pkg::CFG_W-1:0] cfg_wdata
);
	import tmtfc_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic [LIM_W-1:0] lim_q;
	cfg_t             cfg;
	logic             seq_idle;
	logic             res_free;
	logic             res_load;
	result_t          res;
	result_t          res_q;
	logic             res_vld_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			lim_q <= LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				CFG_LIMIT:     lim_q <= cfg_wdata[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.threshold = thr_q;
	assign cfg.limit     = clamp_limit(lim_q);

	assign in_ch.ready = seq_idle;

	tmtfc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_ch.valid && in_ch.ready),
		.cmd     (in_ch.cmd),
		.key     (in_ch.access_key),
		.cfg     (cfg),
		.idle    (seq_idle),
		.res_free(res_free),
		.res_load(res_load),
		.res     (res)
	);

	// output register
	assign res_free = !res_vld_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = res_vld_q;
	assign out_ch.hit          = res_q.hit;
	assign out_ch.entry_count  = res_q.count;
	assign out_ch.promoted     = res_q.promoted;
	assign out_ch.evicted      = res_q.evicted;
	assign out_ch.evicted_key  = res_q.ev_key;
	assign out_ch.evicted_hits = res_q.ev_hits;
	assign out_ch.occupancy    = res_q.occupancy;

endmodule

>>> rtl/tmtfc_ram.sv
// generic simple dual-port ram with registered read
module tmtfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tmtfc_seq.sv
// list sequencer: search, shift and evict over the entry ram
module tmtfc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              cmd,
	input  tmtfc_pkg::key_t   key,
	input  tmtfc_pkg::cfg_t   cfg,
	output logic              idle,
	input  logic              res_free,
	output logic              res_load,
	output tmtfc_pkg::result_t res
);
	import tmtfc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_FRONT  = 3'd3;
	localparam logic [2:0] S_CHK    = 3'd4;
	localparam logic [2:0] S_EVRD   = 3'd5;
	localparam logic [2:0] S_EVCAP  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	key_t       key_q;
	logic       hit_q;
	count_t     cnt_q;
	logic       prom_q;
	logic       ev_q;
	key_t       evk_q;
	count_t     evh_q;
	tot_t       total_q;
	logic       grow_q;
	tot_t       ra_q;
	logic       cmp_vld_q;
	idx_t       cmp_idx_q;
	idx_t       src_q;
	logic       src_more_q;
	logic       sh_vld_q;
	idx_t       sh_dst_q;

	logic                ram_we;
	idx_t                ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic                ram_re;
	idx_t                ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;

	key_t   rd_key;
	count_t rd_hits;
	count_t cnt_inc;
	logic   match;
	logic   do_prom;
	logic   more_rd;
	tot_t   tot_m1;
	tot_t   tot_m2;

	tmtfc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// compare and count update on the word read back
	assign rd_key  = ram_rdata[ENT_W-1:COUNT_WIDTH];
	assign rd_hits = ram_rdata[COUNT_WIDTH-1:0];
	assign cnt_inc = (rd_hits == COUNT_MAX) ? rd_hits : rd_hits + count_t'(1);
	assign match   = cmp_vld_q && (rd_key == key_q);
	assign do_prom = (cnt_inc > cfg.threshold) && (cmp_idx_q != '0);
	assign more_rd = (ra_q < total_q);
	assign tot_m1  = total_q - tot_t'(1);
	assign tot_m2  = total_q - tot_t'(2);

	// ram port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {key_q, cnt_q};
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_SEARCH: begin
				ram_re    = more_rd;
				ram_raddr = ra_q[IDX_W-1:0];
				if (match && !do_prom) begin
					ram_we    = 1'b1;
					ram_waddr = cmp_idx_q;
					ram_wdata = {key_q, cnt_inc};
				end
			end
			S_SHIFT: begin
				ram_re    = src_more_q;
				ram_raddr = src_q;
				ram_we    = sh_vld_q;
				ram_waddr = sh_dst_q;
				ram_wdata = ram_rdata;
			end
			S_FRONT: begin
				ram_we = 1'b1;
			end
			S_EVRD: begin
				ram_re    = 1'b1;
				ram_raddr = tot_m1[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			total_q    <= '0;
			cmp_vld_q  <= 1'b0;
			src_more_q <= 1'b0;
			sh_vld_q   <= 1'b0;
			grow_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q  <= key;
						hit_q  <= 1'b0;
						prom_q <= 1'b0;
						ev_q   <= 1'b0;
						evk_q  <= '0;
						evh_q  <= '0;
						grow_q <= 1'b0;
						if (cmd == CMD_CLEAR) begin
							total_q <= '0;
							cnt_q   <= '0;
							state_q <= S_DONE;
						end else begin
							ra_q      <= '0;
							cmp_vld_q <= 1'b0;
							state_q   <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (match) begin
						hit_q     <= 1'b1;
						cnt_q     <= cnt_inc;
						cmp_vld_q <= 1'b0;
						if (do_prom) begin
							prom_q     <= 1'b1;
							src_q      <= cmp_idx_q - idx_t'(1);
							src_more_q <= 1'b1;
							sh_vld_q   <= 1'b0;
							state_q    <= S_SHIFT;
						end else begin
							state_q <= S_CHK;
						end
					end else if (!cmp_vld_q && !more_rd) begin
						// key absent
						cnt_q <= count_t'(1);
						if (total_q >= cfg.limit) begin
							state_q <= S_EVRD;
						end else begin
							grow_q <= 1'b1;
							if (total_q == '0) begin
								state_q <= S_FRONT;
							end else begin
								src_q      <= tot_m1[IDX_W-1:0];
								src_more_q <= 1'b1;
								sh_vld_q   <= 1'b0;
								state_q    <= S_SHIFT;
							end
						end
					end else begin
						cmp_vld_q <= more_rd;
						cmp_idx_q <= ra_q[IDX_W-1:0];
						ra_q      <= ra_q + tot_t'(1);
					end
				end
				S_SHIFT: begin
					// read one entry ahead, write it one place back
					if (src_more_q) begin
						sh_vld_q <= 1'b1;
						sh_dst_q <= src_q + idx_t'(1);
						if (src_q == '0) begin
							src_more_q <= 1'b0;
						end else begin
							src_q <= src_q - idx_t'(1);
						end
					end else begin
						sh_vld_q <= 1'b0;
					end
					if (!src_more_q && !sh_vld_q) begin
						state_q <= S_FRONT;
					end
				end
				S_FRONT: begin
					if (grow_q) begin
						total_q <= total_q + tot_t'(1);
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (hit_q && (total_q > cfg.limit)) begin
						state_q <= S_EVRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EVRD: begin
					state_q <= S_EVCAP;
				end
				S_EVCAP: begin
					ev_q  <= 1'b1;
					evk_q <= rd_key;
					evh_q <= rd_hits;
					if (hit_q) begin
						total_q <= tot_m1;
						state_q <= S_DONE;
					end else if (tot_m1 == '0) begin
						state_q <= S_FRONT;
					end else begin
						// old tail gone, shift the rest over its slot
						src_q      <= tot_m2[IDX_W-1:0];
						src_more_q <= 1'b1;
						sh_vld_q   <= 1'b0;
						state_q    <= S_SHIFT;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result hand-off
	assign idle     = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && res_free;

	always_comb begin
		res.hit       = hit_q;
		res.count     = cnt_q;
		res.promoted  = prom_q;
		res.evicted   = ev_q;
		res.ev_key    = evk_q;
		res.ev_hits   = evh_q;
		res.occupancy = total_q;
	end

endmodule

>>> rtl/tmtfc_chk.sv
// port-level checks of the result channel, bound to the top level
module tmtfc_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                hit,
	input tmtfc_pkg::count_t   entry_count,
	input logic                promoted,
	input logic                evicted,
	input tmtfc_pkg::key_t     evicted_key,
	input tmtfc_pkg::count_t   evicted_hits,
	input tmtfc_pkg::tot_t     occupancy
);
	import tmtfc_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a missed or cleared item never reports a move and has count at most one
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> !promoted && (entry_count <= count_t'(1)))
		else $error("miss reports promotion or count above one");

	// no eviction means zero eviction fields
	a_noev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> (evicted_key == '0) && (evicted_hits == '0))
		else $error("eviction fields set without eviction");

	// a hit has a live count and a nonempty list
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (entry_count != '0) && (occupancy != '0))
		else $error("hit with zero count or empty list");

endmodule

bind threshold_move_to_front_cache tmtfc_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.hit         (out_ch.hit),
	.entry_count (out_ch.entry_count),
	.promoted    (out_ch.promoted),
	.evicted     (out_ch.evicted),
	.evicted_key (out_ch.evicted_key),
	.evicted_hits(out_ch.evicted_hits),
	.occupancy   (out_ch.occupancy)
);

>>> tb/sv/tb_threshold_move_to_front_cache.sv
// testbench of the move-to-front key cache: own list model, random traffic and stalls
`timescale 1ns / 100ps

module tb_threshold_move_to_front_cache;
	import tmtfc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wen;
	logic                cfg_idx;
	logic [CFG_W-1:0]    cfg_wdata;

	tmtfc_in_if  req_ch();
	tmtfc_out_if rsp_ch();

	threshold_move_to_front_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (rsp_ch),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// mirror of the cache list and its registers
	key_t             list_keys [MAX_ENTRIES];
	count_t           list_hits [MAX_ENTRIES];
	int               list_total;
	logic [THR_W-1:0] promo_threshold;
	logic [LIM_W-1:0] limit_reg;

	result_t pending_results[$];

	int errors;
	int items_sent;
	int clears_sent;
	int hits_seen;
	int promotions_seen;
	int evictions_seen;
	int src_mode;
	int sink_mode;
	int stall_left;

	always #10 clk = ~clk;

	// shift entries before pos back by one and put the key at the front
	function automatic void bring_to_front(int pos, key_t key, count_t cnt);
		int i;
		for (i = pos; i > 0; i--) begin
			list_keys[i] = list_keys[i-1];
			list_hits[i] = list_hits[i-1];
		end
		list_keys[0] = key;
		list_hits[0] = cnt;
	endfunction

	// next list state and the result of one item
	function automatic result_t cache_lookup(logic cmd, key_t key);
		result_t res;
		int      lim;
		int      pos;
		int      i;
		bit      found;
		count_t  cnt;
		res   = '0;
		found = 1'b0;
		pos   = 0;
		if (limit_reg == '0)
			lim = 1;
		else if (int'(limit_reg) > MAX_ENTRIES)
			lim = MAX_ENTRIES;
		else
			lim = int'(limit_reg);
		if (cmd == CMD_CLEAR) begin
			list_total = 0;
		end else begin
			for (i = 0; i < list_total; i++) begin
				if (!found && list_keys[i] == key) begin
					found = 1'b1;
					pos   = i;
				end
			end
			if (found) begin
				res.hit = 1'b1;
				cnt = list_hits[pos];
				if (cnt != COUNT_MAX)
					cnt = cnt + count_t'(1);
				list_hits[pos] = cnt;
				res.count = cnt;
				if (cnt > promo_threshold && pos != 0) begin
					bring_to_front(pos, key, cnt);
					res.promoted = 1'b1;
				end
				// a lowered limit drops one tail entry per access
				if (list_total > lim) begin
					list_total--;
					res.evicted = 1'b1;
					res.ev_key  = list_keys[list_total];
					res.ev_hits = list_hits[list_total];
				end
			end else begin
				res.count = count_t'(1);
				if (list_total + 1 > lim) begin
					res.evicted = 1'b1;
					res.ev_key  = list_keys[list_total-1];
					res.ev_hits = list_hits[list_total-1];
					bring_to_front(list_total - 1, key, count_t'(1));
				end else begin
					bring_to_front(list_total, key, count_t'(1));
					list_total++;
				end
			end
		end
		res.occupancy = tot_t'(list_total);
		return res;
	endfunction

	// gap before the next item, mostly short
	function automatic int pick_gap();
		int r;
		if (src_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((src_mode == 2) ? 30 : 60))
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one item and wait for it to be taken; called just after a falling edge
	task automatic send_item(input logic cmd, input key_t key);
		int      gap;
		result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.access_key <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		res = cache_lookup(cmd, key);
		pending_results.push_back(res);
		items_sent++;
		if (cmd == CMD_CLEAR)
			clears_sent++;
		hits_seen       += int'(res.hit);
		promotions_seen += int'(res.promoted);
		evictions_seen  += int'(res.evicted);
		@(negedge clk);
	endtask

	// hold off the sender until every result is back
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	// write both registers once the block is idle
	task automatic load_config(input logic [CFG_W-1:0] thr_data,
		input logic [CFG_W-1:0] lim_data);
		wait_drain();
		cfg_wen   <= 1'b1;
		cfg_idx   <= CFG_THRESHOLD;
		cfg_wdata <= thr_data;
		@(negedge clk);
		cfg_idx   <= CFG_LIMIT;
		cfg_wdata <= lim_data;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		promo_threshold = thr_data[THR_W-1:0];
		limit_reg       = lim_data[LIM_W-1:0];
		@(negedge clk);
	endtask

	// defaults: miss, hit below and above the threshold, front entry, clear
	task automatic test_basic_access();
		src_mode  = 1;
		sink_mode = 1;
		send_item(CMD_ACCESS, 32'h0000_0000);
		send_item(CMD_ACCESS, 32'hFFFF_FFFF);
		send_item(CMD_ACCESS, 32'h0000_0000);
		send_item(CMD_ACCESS, 32'h0000_0000);
		send_item(CMD_ACCESS, 32'h0000_0000);
		send_item(CMD_ACCESS, 32'hFFFF_FFFF);
		send_item(CMD_CLEAR,  32'hA5A5_A5A5);
		send_item(CMD_ACCESS, 32'h0000_0000);
	endtask

	// limit zero, masked limit writes, limit lowered under a full list
	task automatic test_limit_edges();
		load_config(8'd0, 8'd0);
		send_item(CMD_ACCESS, 32'h0000_0001);
		send_item(CMD_ACCESS, 32'h0000_0002);
		send_item(CMD_ACCESS, 32'h0000_0002);
		load_config(8'd0, 8'hE3);
		send_item(CMD_CLEAR,  32'h0000_0000);
		send_item(CMD_ACCESS, 32'h0000_0010);
		send_item(CMD_ACCESS, 32'h0000_0011);
		send_item(CMD_ACCESS, 32'h0000_0012);
		send_item(CMD_ACCESS, 32'h0000_0013);
		send_item(CMD_ACCESS, 32'h0000_0011);
		// the accessed tail entry is itself the one dropped
		load_config(8'd255, 8'd2);
		send_item(CMD_ACCESS, 32'h0000_0012);
		send_item(CMD_ACCESS, 32'h0000_0013);
	endtask

	// hammer one entry until its count saturates, then let it promote
	task automatic test_count_saturation();
		int n;
		load_config(8'd255, 8'd31);
		send_item(CMD_CLEAR,  32'h0);
		send_item(CMD_ACCESS, 32'h5A5A_0001);
		send_item(CMD_ACCESS, 32'h5A5A_0002);
		src_mode  = 0;
		sink_mode = 0;
		for (n = 0; n < 258; n++)
			send_item(CMD_ACCESS, 32'h5A5A_0001);
		load_config(8'd254, 8'd16);
		send_item(CMD_ACCESS, 32'h5A5A_0001);
	endtask

	// phases of random traffic over small key pools, one setting per phase
	task automatic test_random_traffic();
		logic [CFG_W-1:0] thr_tab [8];
		logic [CFG_W-1:0] lim_tab [8];
		key_t             key_pool[$];
		int               ph;
		int               n;
		int               r;
		int               pool_n;
		thr_tab = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd4, 8'd2};
		lim_tab = '{8'd16, 8'd1, 8'd31, 8'd5, 8'd17, 8'hF0, 8'h20, 8'd10};
		for (ph = 0; ph < 8; ph++) begin
			load_config(thr_tab[ph], lim_tab[ph]);
			src_mode  = ph % 3;
			sink_mode = (ph + 1) % 3;
			pool_n    = $urandom_range(3, 20);
			key_pool.delete();
			for (n = 0; n < pool_n; n++)
				key_pool.push_back($urandom());
			for (n = 0; n < 70; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					send_item(CMD_CLEAR, $urandom());
				else if (r < 10)
					send_item(CMD_ACCESS, $urandom());
				else if (r < 55)
					send_item(CMD_ACCESS, key_pool[$urandom_range(0, 2)]);
				else
					send_item(CMD_ACCESS, key_pool[$urandom_range(0, pool_n - 1)]);
				if ($urandom_range(0, 99) == 0)
					wait_drain();
			end
		end
	endtask

	// receiver stalls, mostly short with a few long ones
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (sink_mode != 0 && $urandom_range(0, 99) < ((sink_mode == 2) ? 40 : 15))
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item, occupancy %0d", $time, rsp_ch.occupancy);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				check_field("hit", 32'(exp_res.hit), 32'(rsp_ch.hit));
				check_field("entry_count", 32'(exp_res.count), 32'(rsp_ch.entry_count));
				check_field("promoted", 32'(exp_res.promoted), 32'(rsp_ch.promoted));
				check_field("evicted", 32'(exp_res.evicted), 32'(rsp_ch.evicted));
				check_field("evicted_key", exp_res.ev_key, rsp_ch.evicted_key);
				check_field("evicted_hits", 32'(exp_res.ev_hits), 32'(rsp_ch.evicted_hits));
				check_field("occupancy", 32'(exp_res.occupancy), 32'(rsp_ch.occupancy));
			end
		end
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_idx           = CFG_THRESHOLD;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_ACCESS;
		req_ch.access_key = '0;
		rsp_ch.ready      = 1'b0;
		stall_left        = 0;
		src_mode          = 0;
		sink_mode         = 0;
		errors            = 0;
		items_sent        = 0;
		clears_sent       = 0;
		hits_seen         = 0;
		promotions_seen   = 0;
		evictions_seen    = 0;
		list_total        = 0;
		promo_threshold   = THRESHOLD_RST;
		limit_reg         = LIMIT_RST;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_access();
		test_limit_edges();
		test_count_saturation();
		test_random_traffic();

		// let any stray result show up
		wait_drain();
		repeat (60) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d result items never arrived", $time, pending_results.size());
			errors++;
		end
		$display("run covered %0d items (%0d clears) over 13 register settings",
			items_sent, clears_sent);
		$display("hits %0d, promotions %0d, evictions %0d, mismatches %0d",
			hits_seen, promotions_seen, evictions_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
rtl/tmtfc_pkg.sv
rtl/tmtfc_if.sv
rtl/tmtfc_ram.sv
rtl/tmtfc_seq.sv
rtl/threshold_move_to_front_cache.sv
rtl/tmtfc_chk.sv
tb/sv/tb_threshold_move_to_front_cache.sv
